// ----- rtl/core/sgpj_pkg.sv -----
// ---------------------------------------------------------------------------
// Shifted Gaussian profile Jacobian package
// Shared types, constants and fixed point helpers.
// ---------------------------------------------------------------------------
package sgpj_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int EXP_SEGMENTS = 256;
    localparam int EXP_RANGE    = 32;
    localparam int SEG_BITS     = $clog2(EXP_SEGMENTS);
    localparam int POS_SHIFT    = $clog2(EXP_RANGE) - SEG_BITS;
    localparam int NODE_W       = FRAC_BITS + 1;

    localparam logic [2:0] REG_HEIGHT = 3'd0;
    localparam logic [2:0] REG_CENTRE = 3'd1;
    localparam logic [2:0] REG_WEIGHT = 3'd2;
    localparam logic [2:0] REG_SLOPE  = 3'd3;
    localparam logic [2:0] REG_THETA  = 3'd4;
    localparam logic [2:0] REG_OFFSET = 3'd5;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] profile_value;
        logic [16:0]        d_height;
        logic signed [31:0] d_centre;
        logic signed [31:0] d_weight;
        logic signed [31:0] d_slope;
        logic               last_out;
    } t_out;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] centre;
        logic [30:0]        weight;
        logic signed [31:0] cf;
        logic signed [31:0] one_plus;
        logic signed [31:0] centre_eff;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Round half up then floor by FRAC_BITS; arithmetic shift is a floor.
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        p = p + (66'sd1 <<< (FRAC_BITS - 1));
        return sat32(p >>> FRAC_BITS);
    endfunction

    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] step_ratio();
        logic [63:0] h;
        logic [63:0] term;
        logic signed [63:0] sum;
        h = ((64'(EXP_RANGE) << 30) + 64'(EXP_SEGMENTS / 2)) / 64'(EXP_SEGMENTS);
        term = 64'd1 << 30;
        sum = 64'sd1 <<< 30;
        for (int i = 1; i <= 30; i++) begin
            term = mul30(term, h) / 64'(i);
            if (i % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        return sum;
    endfunction

    function automatic logic [NODE_W-1:0] exp_node(input int k);
        logic [63:0] acc;
        logic [63:0] base;
        int kk;
        acc = 64'd1 << 30;
        base = step_ratio();
        kk = k;
        while (kk != 0) begin
            if (kk % 2 == 1) acc = mul30(acc, base);
            base = mul30(base, base);
            kk = kk / 2;
        end
        if (30 - FRAC_BITS > 0)
            acc = (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return acc[NODE_W-1:0];
    endfunction

endpackage

// ----- rtl/core/sgpj_exp.sv -----
// ---------------------------------------------------------------------------
// Exponential stages
// Registered table lookup of two nodes, then combinational linear interpolation.
// ---------------------------------------------------------------------------
module sgpj_exp (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic signed [31:0] i_arg,
    output logic [sgpj_pkg::NODE_W-1:0] o_e
);
    localparam int NODE_W_OUT = sgpj_pkg::NODE_W;
    localparam int N = sgpj_pkg::EXP_SEGMENTS;
    localparam int F = sgpj_pkg::FRAC_BITS;
    localparam int SB = sgpj_pkg::SEG_BITS;

    logic [NODE_W_OUT-1:0] c_nodes [0:N-1];
    logic [NODE_W_OUT-1:0] c_last;
    logic [31:0] w_a;
    logic [47:0] w_p;
    logic [SB-1:0] w_idx;
    logic [NODE_W_OUT-1:0] r_n0, n_n0, r_n1, n_n1;
    logic [F-1:0] r_frac, n_frac;
    logic signed [65:0] w_prod;

    always_comb begin
        for (int k = 0; k < N; k++) c_nodes[k] = sgpj_pkg::exp_node(k);
        c_last = sgpj_pkg::exp_node(N);
    end

    always_comb begin
        w_a = i_arg[31] ? 32'd0 : i_arg;
        w_p = (sgpj_pkg::POS_SHIFT >= 0) ? (48'(w_a) >> sgpj_pkg::POS_SHIFT)
                                          : (48'(w_a) << (-sgpj_pkg::POS_SHIFT));
        n_frac = w_p[F-1:0];
        w_idx = w_p[F+SB-1:F];
        if (w_p[47:F] >= (48-F)'(N)) begin
            n_n0 = '0;
            n_n1 = '0;
        end else begin
            n_n0 = c_nodes[w_idx];
            n_n1 = (w_idx == SB'(N - 1)) ? c_last : c_nodes[w_idx + SB'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0 <= n_n0;
            r_n1 <= n_n1;
            r_frac <= n_frac;
        end
    end

    always_comb begin
        w_prod = (66'($signed({1'b0, r_n1})) - 66'($signed({1'b0, r_n0})))
                 * 66'($signed({1'b0, r_frac}));
        w_prod = (w_prod + (66'sd1 <<< (F - 1))) >>> F;
        o_e = NODE_W_OUT'(66'(r_n0) + w_prod);
    end
endmodule

// ----- rtl/core/sgpj_cfg.sv -----
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the registers and derives cf, one_plus and the effective centre in turn.
// ---------------------------------------------------------------------------
module sgpj_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_index,
    input  logic [31:0] i_data,
    output sgpj_pkg::t_cfg o_cfg,
    output logic        o_busy
);
    logic signed [31:0] r_height, r_centre, r_slope, r_theta, r_offset, r_cf, r_op, r_ce;
    logic [30:0] r_weight;
    logic [1:0] r_settle;
    logic [31:0] w_mag;
    logic [63:0] w_q;
    logic signed [31:0] n_cf;

    always_comb begin
        w_mag = r_theta[31] ? 32'(-r_theta) : r_theta;
        w_q = ((64'(w_mag) + 64'd500) * 64'd4398046512) >> 42;
        n_cf = r_theta[31] ? -$signed(w_q[31:0]) : $signed(w_q[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0; r_centre <= '0; r_slope <= '0; r_theta <= '0;
            r_offset <= '0; r_weight <= 31'd65536; r_cf <= '0;
            r_op <= 32'sd1 <<< sgpj_pkg::FRAC_BITS; r_ce <= '0;
            r_settle <= '0;
        end else begin
            if (i_valid) begin
                case (i_index)
                    sgpj_pkg::REG_HEIGHT: r_height <= i_data;
                    sgpj_pkg::REG_CENTRE: r_centre <= i_data;
                    sgpj_pkg::REG_WEIGHT: r_weight <= i_data[30:0];
                    sgpj_pkg::REG_SLOPE:  r_slope  <= i_data;
                    sgpj_pkg::REG_THETA:  r_theta  <= i_data;
                    sgpj_pkg::REG_OFFSET: r_offset <= i_data;
                    default: ;
                endcase
            end
            if (i_valid) r_settle <= 2'd3;
            else if (r_settle != 2'd0) r_settle <= r_settle - 2'd1;
            r_cf <= n_cf;
            r_op <= sgpj_pkg::sat32(66'(32'sd1 <<< sgpj_pkg::FRAC_BITS)
                    + 66'(sgpj_pkg::mulq(r_slope, 33'(r_cf))));
            r_ce <= sgpj_pkg::sat32(66'(sgpj_pkg::mulq(r_centre, 33'(r_op))) + 66'(r_offset));
        end
    end

    assign o_cfg = '{r_height, r_centre, r_weight, r_cf, r_op, r_ce};
    assign o_busy = (r_settle != 2'd0);
endmodule

// ----- rtl/core/shifted_gaussian_profile_jacobian_top.sv -----
// ---------------------------------------------------------------------------
// Shifted Gaussian profile Jacobian
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits on a stalled output.
// Reset clears valid bits and loads register reset values; after a
// configuration write the input stalls while derived terms settle.
// ---------------------------------------------------------------------------
module shifted_gaussian_profile_jacobian_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sgpj_pkg::t_in       i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sgpj_pkg::t_out      o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int S = 11;
    localparam logic signed [32:0] HALF = 33'sd1 <<< (sgpj_pkg::FRAC_BITS - 1);

    sgpj_pkg::t_cfg w_cfg;
    logic w_en;
    logic w_busy;
    logic w_take;
    logic [S-1:0] r_v;
    logic [S-1:0] r_last;
    logic signed [31:0] r_d [1:7], r_d2 [2:7], r_a3, r_a4, r_prof [7:S];
    logic signed [31:0] r_b8, r_b9, r_dw8, r_dw9, r_dw10, r_dw11;
    logic signed [31:0] r_dc10, r_dc11, r_bc10, r_ds11;
    logic [sgpj_pkg::NODE_W-1:0] w_e;
    logic [sgpj_pkg::NODE_W-1:0] r_e [6:S];
    logic signed [31:0] n_d;

    sgpj_cfg u_cfg (.i_clk, .i_rst_n, .i_valid(i_cfg_valid), .i_index(i_cfg_index),
                    .i_data(i_cfg_data), .o_cfg(w_cfg), .o_busy(w_busy));
    assign o_cfg_ready = 1'b1;

    assign w_en = !(r_v[S-1] && i_stall);
    assign o_stall = !w_en || w_busy;
    assign w_take = i_valid && !w_busy;

    sgpj_exp u_exp (.i_clk, .i_en(w_en), .i_arg(r_a4), .o_e(w_e));

    assign n_d = sgpj_pkg::sat32(66'(i_data.x_position) - 66'(w_cfg.centre_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (w_en) r_v <= {r_v[S-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[S-2:0], i_data.is_last};
            r_d[1] <= n_d;
            for (int k = 2; k <= 7; k++) r_d[k] <= r_d[k-1];
            r_d2[2] <= sgpj_pkg::mulq(r_d[1], 33'(r_d[1]));
            for (int k = 3; k <= 7; k++) r_d2[k] <= r_d2[k-1];
            r_a3 <= sgpj_pkg::mulq(r_d2[2], 33'({1'b0, w_cfg.weight}));
            r_a4 <= sgpj_pkg::mulq(r_a3, HALF);
            r_e[6] <= w_e;
            for (int k = 7; k <= S; k++) r_e[k] <= r_e[k-1];
            r_prof[7] <= sgpj_pkg::mulq(w_cfg.height, 33'(r_e[6]));
            for (int k = 8; k <= S; k++) r_prof[k] <= r_prof[k-1];
            r_b8 <= sgpj_pkg::mulq(r_prof[7], 33'(r_d[7]));
            r_dw8 <= sgpj_pkg::mulq(r_d2[7], 33'(r_prof[7]));
            r_b9 <= sgpj_pkg::mulq(r_b8, 33'({1'b0, w_cfg.weight}));
            r_dw9 <= sgpj_pkg::mulq(r_dw8, -HALF);
            r_dc10 <= sgpj_pkg::mulq(r_b9, 33'(w_cfg.one_plus));
            r_bc10 <= sgpj_pkg::mulq(r_b9, 33'(w_cfg.cf));
            r_dw10 <= r_dw9;
            r_dc11 <= r_dc10;
            r_dw11 <= r_dw10;
            r_ds11 <= sgpj_pkg::mulq(r_bc10, 33'(w_cfg.centre));
        end
    end

    assign o_valid = r_v[S-1];
    assign o_data = '{r_prof[S], r_e[S][16:0], r_dc11, r_dw11, r_ds11, r_last[S-1]};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result lost");
    a_stall_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == ((o_valid && i_stall) || w_busy)) else $error("stall mismatch");
endmodule

// ----- sim/shifted_gaussian_profile_jacobian_top_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Shifted Gaussian profile Jacobian testbench
// Drives x positions through the block under several register settings,
// predicts each profile value and its Jacobian in fixed point, and compares
// every result transaction with the oldest prediction, with random idling on
// both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------
module shifted_gaussian_profile_jacobian_top_test;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    sgpj_pkg::t_in    i_data;
    logic             o_valid;
    logic             i_stall;
    sgpj_pkg::t_out   o_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [2:0]       i_cfg_index;
    logic [31:0]      i_cfg_data;

    shifted_gaussian_profile_jacobian_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    longint height_q, centre_q, weight_q, slope_q, theta_q, offset_q;
    longint exp_nodes [0:256];
    sgpj_pkg::t_out expected_points [$];
    int     error_count;
    int     hold_cycles;
    int     stall_run;
    int     stall_pct;
    bit     quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul_q(longint a, longint b);
        return sat_q((a * b + 64'sd32768) >>> 16);
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint div_thousand(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 500) / 1000;
        return (v < 0) ? -m : m;
    endfunction

    task automatic build_exp_nodes();
        longint h, term, ratio, acc, base;
        int kk;
        h = ((64'sd32 <<< 30) + 128) / 256;
        term = 64'sd1 <<< 30;
        ratio = 64'sd1 <<< 30;
        for (int i = 1; i <= 30; i++) begin
            term = mul_q30(term, h) / i;
            ratio = (i % 2 == 1) ? ratio - term : ratio + term;
        end
        if (ratio < 0) ratio = 0;
        for (int k = 0; k <= 256; k++) begin
            acc = 64'sd1 <<< 30;
            base = ratio;
            kk = k;
            while (kk != 0) begin
                if (kk % 2 == 1) acc = mul_q30(acc, base);
                base = mul_q30(base, base);
                kk = kk / 2;
            end
            exp_nodes[k] = (acc + (64'sd1 <<< 13)) >>> 14;
        end
    endtask

    function automatic longint gauss_decay(longint a);
        longint p, idx, frac;
        if (a < 0) a = 0;
        p = a * 8;
        idx = p >>> 16;
        if (idx >= 256) return 0;
        frac = p & 64'hFFFF;
        return exp_nodes[idx] +
               ((((exp_nodes[idx + 1] - exp_nodes[idx]) * frac) + 64'sd32768) >>> 16);
    endfunction

    function automatic longint shift_plus_one();
        return sat_q(65536 + mul_q(slope_q, div_thousand(theta_q)));
    endfunction

    function automatic longint effective_centre();
        return sat_q(mul_q(centre_q, shift_plus_one()) + offset_q);
    endfunction

    function automatic sgpj_pkg::t_out predict_point(sgpj_pkg::t_in pt);
        sgpj_pkg::t_out r;
        longint cf, one_plus, d, d2, e, prof, b;
        cf = div_thousand(theta_q);
        one_plus = shift_plus_one();
        d = sat_q(longint'(pt.x_position) - effective_centre());
        d2 = mul_q(d, d);
        e = gauss_decay(mul_q(mul_q(d2, weight_q), 32768));
        prof = mul_q(height_q, e);
        b = mul_q(mul_q(prof, d), weight_q);
        r.profile_value = prof[31:0];
        r.d_height = e[16:0];
        r.d_centre = 32'(mul_q(b, one_plus));
        r.d_weight = 32'(mul_q(mul_q(d2, prof), -32768));
        r.d_slope = 32'(mul_q(mul_q(b, cf), centre_q));
        r.last_out = pt.is_last;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        sgpj_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected transaction", o_data.profile_value, 32'h0);
            end else begin
                want = expected_points.pop_front();
                check_field("profile_value", o_data.profile_value, want.profile_value);
                check_field("d_height", 32'(o_data.d_height), 32'(want.d_height));
                check_field("d_centre", o_data.d_centre, want.d_centre);
                check_field("d_weight", o_data.d_weight, want.d_weight);
                check_field("d_slope", o_data.d_slope, want.d_slope);
                check_field("last_out", 32'(o_data.last_out), 32'(want.last_out));
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        stall_run = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else if (stall_run > 0) begin
                stall_run--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 3) begin
                stall_run = $urandom_range(10, 30);
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_point(logic [31:0] x, logic last);
        sgpj_pkg::t_in pt;
        int  gap;
        gap = gap_length();
        pt.x_position = x;
        pt.is_last = last;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= pt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_points.push_back(predict_point(pt));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            sgpj_pkg::REG_HEIGHT: height_q = longint'(signed'(value));
            sgpj_pkg::REG_CENTRE: centre_q = longint'(signed'(value));
            sgpj_pkg::REG_WEIGHT: weight_q = longint'(value[30:0]);
            sgpj_pkg::REG_SLOPE:  slope_q  = longint'(signed'(value));
            sgpj_pkg::REG_THETA:  theta_q  = longint'(signed'(value));
            sgpj_pkg::REG_OFFSET: offset_q = longint'(signed'(value));
            default: ;
        endcase
        repeat (5) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] h, logic [31:0] c, logic [31:0] w,
                           logic [31:0] s, logic [31:0] t, logic [31:0] o);
        wait_idle();
        write_register(sgpj_pkg::REG_HEIGHT, h);
        write_register(sgpj_pkg::REG_CENTRE, c);
        write_register(sgpj_pkg::REG_WEIGHT, w);
        write_register(sgpj_pkg::REG_SLOPE, s);
        write_register(sgpj_pkg::REG_THETA, t);
        write_register(sgpj_pkg::REG_OFFSET, o);
    endtask

    task automatic test_reset_values();
        send_point(32'h0, 1'b0);
        send_point(32'h0001_0000, 1'b1);
        send_point(32'hFFFF_0000, 1'b0);
    endtask

    task automatic test_extremes();
        set_all(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h0000_8000, 1'b0);
        send_point(32'h0008_0000, 1'b1);
        send_point(32'h0007_FFFF, 1'b0);
        set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 1'b1);
        send_point(32'h0, 1'b0);
        set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h1234_5678, 1'b0);
        set_all(32'h0002_0000, 32'h0003_0000, 32'hFFFF_FFFF,
                32'h0000_8000, 32'h03E8_0000, 32'hFFFF_0000);
        send_point(32'h0002_0000, 1'b0);
        send_point(32'h0002_0001, 1'b1);
    endtask

    task automatic test_unused_index();
        wait_idle();
        write_register(3'd6, 32'hDEAD_BEEF);
        write_register(3'd7, 32'h1234_5678);
        send_point(32'h0002_8000, 1'b1);
        send_point(32'h0001_0000, 1'b0);
    endtask

    function automatic logic [31:0] near_peak_x();
        longint c, spread;
        if ($urandom_range(0, 99) < 15) return $urandom;
        c = effective_centre();
        spread = 64'sd1 <<< $urandom_range(4, 22);
        return 32'(sat_q(c + $urandom_range(0, 2 * spread) - spread));
    endfunction

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            stall_pct = $urandom_range(0, 40);
            quiet = (phase == 3);
            set_all($urandom_range(0, 1) ? $urandom : (32'($urandom_range(0, 1 << 20)) - (1 << 19)),
                    32'($urandom_range(0, 1 << 22)) - (1 << 21),
                    (phase == 5) ? $urandom : (32'h1 << $urandom_range(8, 26)),
                    $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 18)) - (1 << 17),
                    $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 26)) - (1 << 25),
                    $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 20)) - (1 << 19));
            for (int n = 0; n < 105; n++)
                send_point(near_peak_x(), 1'($urandom_range(0, 1)));
        end
        quiet = 1'b0;
    endtask

    task automatic test_receiver_hold_off();
        wait_idle();
        quiet = 1'b1;
        hold_cycles = 150;
        for (int n = 0; n < 40; n++) send_point(near_peak_x(), n == 39);
        quiet = 1'b0;
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = sgpj_pkg::REG_HEIGHT;
        i_cfg_data = '0;
        error_count = 0;
        hold_cycles = 0;
        stall_pct = 20;
        quiet = 1'b0;
        height_q = 0;
        centre_q = 0;
        weight_q = 65536;
        slope_q = 0;
        theta_q = 0;
        offset_q = 0;
        build_exp_nodes();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        test_reset_values();
        test_extremes();
        test_unused_index();
        test_random_settings();
        test_receiver_hold_off();

        i_valid <= 1'b0;
        waited = 0;
        while (expected_points.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_points.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/sgpj_pkg.sv
rtl/core/sgpj_exp.sv
rtl/core/sgpj_cfg.sv
rtl/core/shifted_gaussian_profile_jacobian_top.sv
sim/shifted_gaussian_profile_jacobian_top_test.sv
